/* hw/rtl/decaying_threshold_peak_picker_macros.svh */
// Assertion macros for the decaying-threshold peak picker.
// Included by the top level; no other dependencies.
`ifndef DECAYING_THRESHOLD_PEAK_PICKER_MACROS_SVH
`define DECAYING_THRESHOLD_PEAK_PICKER_MACROS_SVH

`ifndef ASSERT_OFF
`define DTPP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");
`define DTPP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define DTPP_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define DTPP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* hw/rtl/dtpp_pkg.sv */
// Shared types, constants and the local-maximum rule of the peak picker.
// No dependencies; used by every RTL file of the block.
package dtpp_pkg;

   localparam int unsigned MAX_LENGTH_DEFAULT = 65536;

   // Depth must stay a power of two so the pointers wrap on their own.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] MODE_TIE_RIGHT = 2'd0;
   localparam logic [1:0] MODE_TIE_LEFT  = 2'd1;
   localparam logic [1:0] MODE_STRICT    = 2'd2;
   localparam logic [1:0] MODE_TIE_BOTH  = 2'd3;

   localparam logic [1:0] CSR_PEAK_MODE     = 2'd0;
   localparam logic [1:0] CSR_DECAY_RATE    = 2'd1;
   localparam logic [1:0] CSR_MIN_THRESHOLD = 2'd2;

   localparam logic [15:0]        DECAY_RATE_RESET    = 16'd58982;
   localparam logic signed [15:0] MIN_THRESHOLD_RESET = 16'sd0;

   localparam logic signed [31:0] THR_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] THR_MIN = 32'sh8000_0000;
   localparam logic [15:0]        COUNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               frame_end;
   } req_type;

   typedef struct packed {
      logic [15:0]        position;
      logic               peak_flag;
      logic signed [31:0] threshold;
      logic [15:0]        peak_count;
      logic               last;
   } rsp_type;

   // One position handed from the classifier to the threshold unit.
   typedef struct packed {
      logic [15:0]        position;
      logic signed [15:0] sample;
      logic               candidate;
      logic               last;
   } op_type;

   // Zero, one or two positions pushed in one cycle; op_a goes in first.
   typedef struct packed {
      logic [1:0] count;
      op_type     op_a;
      op_type     op_b;
   } push_type;

   function automatic logic is_local_max(logic [1:0] mode, logic signed [15:0] l,
                                         logic signed [15:0] c, logic signed [15:0] r);
      logic result;
      unique case (mode)
         MODE_TIE_RIGHT: result = (c > l) && (c >= r);
         MODE_TIE_LEFT:  result = (c >= l) && (c > r);
         MODE_STRICT:    result = (c > l) && (c > r);
         MODE_TIE_BOTH:  result = (c >= l) && (c >= r);
      endcase
      return result;
   endfunction

endpackage

/* hw/rtl/decaying_threshold_peak_picker.sv */
// Channel   Ports                              Transaction
// req       req_valid/req_ready/req_data       one sample, frame_end marks the last one
// rsp       rsp_valid/rsp_ready/rsp_data       one position: flag, threshold, count, last
// csr       csr_write_en/csr_index/csr_wdata   one register write, no wait
//
// One sample per cycle is accepted while the queue has room. The threshold unit does one
// multiply-add and handles one position per cycle while the result register can take a result;
// the final sample of a frame brings two positions when the frame holds more than one sample.
// A result is registered from the head of the queue once the result register can take it.
// Reset is synchronous and clears all frame state at once; there is no clearing pass.
// The four-entry queue lets intake continue while rsp_ready is low, until fewer than two slots are free.
//
// Top level of the decaying-threshold peak picker: configuration registers and wiring.
// Depends on dtpp_pkg, dtpp_front, dtpp_queue, dtpp_back and the assertion macros.
`include "decaying_threshold_peak_picker_macros.svh"

module decaying_threshold_peak_picker import dtpp_pkg::*; #(
   parameter int unsigned MAX_LENGTH = MAX_LENGTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [1:0]         peak_mode_ff, peak_mode_in;
   logic [15:0]        decay_rate_ff, decay_rate_in;
   logic signed [15:0] min_threshold_ff, min_threshold_in;

   push_type push;
   logic     room;
   logic     pop;
   op_type   q_head;
   logic     q_head_valid;

   assign req_ready = room;

   always_comb begin
      peak_mode_in     = peak_mode_ff;
      decay_rate_in    = decay_rate_ff;
      min_threshold_in = min_threshold_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_PEAK_MODE:     peak_mode_in     = csr_wdata[1:0];
            CSR_DECAY_RATE:    decay_rate_in    = csr_wdata;
            CSR_MIN_THRESHOLD: min_threshold_in = $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_mode_ff     <= MODE_STRICT;
         decay_rate_ff    <= DECAY_RATE_RESET;
         min_threshold_ff <= MIN_THRESHOLD_RESET;
      end else begin
         peak_mode_ff     <= peak_mode_in;
         decay_rate_ff    <= decay_rate_in;
         min_threshold_ff <= min_threshold_in;
      end
   end

   dtpp_front #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .peak_mode (peak_mode_ff),
      .req_valid (req_valid),
      .req_data  (req_data),
      .room      (room),
      .push      (push)
   );

   dtpp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .pop        (pop),
      .head       (q_head),
      .head_valid (q_head_valid)
   );

   dtpp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .decay_rate    (decay_rate_ff),
      .min_threshold (min_threshold_ff),
      .head          (q_head),
      .head_valid    (q_head_valid),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data)
   );

   // An accepted peak is always counted.
   `DTPP_ASSERT_IMPL(a_peak_counted, clock, reset, rsp_valid && rsp_data.peak_flag, rsp_data.peak_count != 16'd0)
   // The final position of a frame is never a peak.
   `DTPP_ASSERT_IMPL(a_last_not_peak, clock, reset, rsp_valid && rsp_data.last, !rsp_data.peak_flag)
   // A queued position with a free result register yields a result next cycle.
   `DTPP_ASSERT_NEXT(a_back_drains, clock, reset, q_head_valid && (!rsp_valid || rsp_ready), rsp_valid)
   // A frame-ending sample always leaves at least one position queued.
   `DTPP_ASSERT_NEXT(a_end_queued, clock, reset, req_valid && req_ready && req_data.frame_end, q_head_valid)

endmodule

/* hw/rtl/dtpp_front.sv */
// Front end: accepts samples, keeps the three-sample window and classifies positions.
// Depends on dtpp_pkg; feeds dtpp_queue.
module dtpp_front import dtpp_pkg::*; #(
   parameter int unsigned MAX_LENGTH = MAX_LENGTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] peak_mode,
   input  logic       req_valid,
   input  req_type    req_data,
   input  logic       room,
   output push_type   push
);

   localparam int unsigned IDX_W = $clog2(MAX_LENGTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_LENGTH - 1);

   logic [1:0]         fill_ff, fill_in;
   logic signed [15:0] older_ff, older_in;
   logic signed [15:0] newer_ff, newer_in;
   logic [15:0]        newer_pos_ff, newer_pos_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;

   logic   accept;
   logic   have_prev;
   op_type win_op;
   op_type end_op;

   assign accept    = req_valid && room;
   assign have_prev = (fill_ff != 2'd0);

   always_comb begin
      win_op.position  = newer_pos_ff;
      win_op.sample    = newer_ff;
      win_op.candidate = (fill_ff == 2'd2)
                         && is_local_max(peak_mode, older_ff, newer_ff, req_data.sample);
      win_op.last      = 1'b0;

      // The frame's final position has no right neighbor, so it is never a peak.
      end_op.position  = 16'(idx_ff);
      end_op.sample    = req_data.sample;
      end_op.candidate = 1'b0;
      end_op.last      = 1'b1;

      push.count = accept ? ({1'b0, have_prev} + {1'b0, req_data.frame_end}) : 2'd0;
      push.op_a  = have_prev ? win_op : end_op;
      push.op_b  = end_op;
   end

   always_comb begin
      fill_in      = fill_ff;
      older_in     = older_ff;
      newer_in     = newer_ff;
      newer_pos_in = newer_pos_ff;
      idx_in       = idx_ff;
      if (accept) begin
         if (req_data.frame_end) begin
            fill_in      = 2'd0;
            older_in     = '0;
            newer_in     = '0;
            newer_pos_in = '0;
            idx_in       = '0;
         end else begin
            older_in     = newer_ff;
            newer_in     = req_data.sample;
            newer_pos_in = 16'(idx_ff);
            fill_in      = (fill_ff == 2'd2) ? 2'd2 : fill_ff + 2'd1;
            idx_in       = (idx_ff == IDX_LAST) ? '0 : idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= 2'd0;
         older_ff     <= '0;
         newer_ff     <= '0;
         newer_pos_ff <= '0;
         idx_ff       <= '0;
      end else begin
         fill_ff      <= fill_in;
         older_ff     <= older_in;
         newer_ff     <= newer_in;
         newer_pos_ff <= newer_pos_in;
         idx_ff       <= idx_in;
      end
   end

endmodule

/* hw/rtl/dtpp_queue.sv */
// Short position queue between the classifier and the threshold unit.
// Depends on dtpp_pkg; takes up to two positions per cycle and releases at most one.
module dtpp_queue import dtpp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   input  logic     pop,
   output op_type   head,
   output logic     head_valid
);

   localparam int unsigned CNT_W = QPTR_W + 1;

   op_type              entry_ff [QUEUE_DEPTH];
   op_type              entry_in [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   // A sample can bring two positions, so room means two free slots.
   assign room       = (count_ff <= CNT_W'(QUEUE_DEPTH - 2));
   assign head       = entry_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);

   always_comb begin
      entry_in = entry_ff;
      if (push.count != 2'd0) begin
         entry_in[wr_ptr_ff] = push.op_a;
      end
      if (push.count == 2'd2) begin
         entry_in[wr_ptr_ff + QPTR_W'(1)] = push.op_b;
      end
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* hw/rtl/dtpp_back.sv */
// Back end: decays the threshold, accepts peaks, counts them and drives the result register.
// Depends on dtpp_pkg; takes positions from dtpp_queue.
module dtpp_back import dtpp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [15:0]        decay_rate,
   input  logic signed [15:0] min_threshold,
   input  op_type             head,
   input  logic               head_valid,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data
);

   logic signed [31:0] thr_ff, thr_in;
   logic [15:0]        count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               take;
   logic signed [48:0] product;
   logic signed [31:0] decayed;
   logic signed [31:0] s256;
   logic               accept;
   logic signed [32:0] sum;
   logic signed [31:0] next_thr;
   logic [15:0]        next_count;

   assign take      = head_valid && (!rsp_valid_ff || rsp_ready);
   assign pop       = take;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      // Rate is unsigned Q0.16; the arithmetic shift floors toward minus infinity.
      product  = thr_ff * $signed({1'b0, decay_rate});
      decayed  = $signed(product[47:16]);
      s256     = {{8{head.sample[15]}}, head.sample, 8'h00};
      accept   = head.candidate && (head.sample > min_threshold) && (s256 > decayed);
      sum      = {decayed[31], decayed} + (accept ? {s256[31], s256} : 33'sd0);
      if (sum[32] != sum[31]) begin
         next_thr = sum[32] ? THR_MIN : THR_MAX;
      end else begin
         next_thr = sum[31:0];
      end
      next_count = (accept && (count_ff != COUNT_MAX)) ? count_ff + 16'd1 : count_ff;

      thr_in       = thr_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (take) begin
         // The frame's final position clears the running state for the next frame.
         thr_in              = head.last ? 32'sd0 : next_thr;
         count_in            = head.last ? 16'd0 : next_count;
         rsp_in.position     = head.position;
         rsp_in.peak_flag    = accept;
         rsp_in.threshold    = next_thr;
         rsp_in.peak_count   = next_count;
         rsp_in.last         = head.last;
         rsp_valid_in        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         thr_ff       <= thr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
